// ===== src/aarm_pkg.sv =====
`default_nettype none
package aarm_pkg;

  localparam int ELEMENT_WIDTH   = 16;
  localparam int FRAC_BITS       = ELEMENT_WIDTH - 2;
  localparam int TRIG_ITERATIONS = 16;
  localparam int CORDIC_STEPS    = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;

  localparam int AXIS_W    = 16;
  localparam int ANGLE_W   = 16;
  localparam int UNIT_FRAC = 30;
  localparam int UNIT_W    = UNIT_FRAC + 2;
  localparam int ROOT_W    = 2 * AXIS_W;
  localparam int QUO_W     = UNIT_W - 1;
  localparam int TRIG_W    = 34;
  localparam int TURN_W    = 32;
  localparam int T_W       = UNIT_W + 1;
  localparam int COL_W     = 2;

  localparam logic [COL_W-1:0] LAST_COL = 2'd3;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = TRIG_W'(652032874);

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [AXIS_W-1:0]        axis_t;
  typedef logic        [ANGLE_W-1:0]       angle_t;
  typedef logic signed [UNIT_W-1:0]        unit_t;
  typedef logic signed [T_W-1:0]           tval_t;

  localparam elem_t ELEM_ONE = elem_t'(64'd1 << FRAC_BITS);

  // unit axis in Q30, components x, y, z at index 0, 1, 2
  typedef struct packed {
    logic              err;
    unit_t [2:0]       u;
    angle_t            angle;
  } norm_out_t;

  typedef struct packed {
    logic              err;
    unit_t [2:0]       u;
    unit_t             c;
    unit_t             s;
    tval_t             t;
  } rot_in_t;

  // [column][row]
  typedef elem_t [2:0][2:0] mat_t;

  typedef struct packed {
    logic err;
    mat_t m;
  } mat_out_t;

  // atan(2^-idx) in units of 2^32 per turn
  function automatic logic signed [TRIG_W-1:0] atan_step(input int idx);
    logic signed [TRIG_W-1:0] v;
    unique case (idx)
      0:  v = TRIG_W'(536870912);
      1:  v = TRIG_W'(316933406);
      2:  v = TRIG_W'(167458907);
      3:  v = TRIG_W'(85004756);
      4:  v = TRIG_W'(42667331);
      5:  v = TRIG_W'(21354465);
      6:  v = TRIG_W'(10679838);
      7:  v = TRIG_W'(5340245);
      8:  v = TRIG_W'(2670163);
      9:  v = TRIG_W'(1335087);
      10: v = TRIG_W'(667544);
      11: v = TRIG_W'(333772);
      12: v = TRIG_W'(166886);
      13: v = TRIG_W'(83443);
      14: v = TRIG_W'(41722);
      15: v = TRIG_W'(20861);
      16: v = TRIG_W'(10430);
      17: v = TRIG_W'(5215);
      18: v = TRIG_W'(2608);
      19: v = TRIG_W'(1304);
      20: v = TRIG_W'(652);
      21: v = TRIG_W'(326);
      22: v = TRIG_W'(163);
      23: v = TRIG_W'(81);
      24: v = TRIG_W'(41);
      25: v = TRIG_W'(20);
      26: v = TRIG_W'(10);
      27: v = TRIG_W'(5);
      28: v = TRIG_W'(3);
      29: v = TRIG_W'(1);
      30: v = TRIG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/aarm_norm.sv =====
`default_nettype none
module aarm_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  aarm_pkg::axis_t     ax_i,
  input  aarm_pkg::axis_t     ay_i,
  input  aarm_pkg::axis_t     az_i,
  input  aarm_pkg::angle_t    angle_i,
  output logic                out_valid_o,
  output aarm_pkg::norm_out_t out_o
);
  import aarm_pkg::*;

  localparam int N2_W      = 2 * AXIS_W;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int MAG_W     = AXIS_W;
  localparam int NUM_SHIFT = UNIT_FRAC + N2_W / 2;
  localparam int NUM_W     = MAG_W + NUM_SHIFT;
  localparam int DIV_STEPS = QUO_W;
  localparam int DREM_W    = ROOT_W;
  localparam int DEPTH     = SQ_STEPS + DIV_STEPS + 3;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  err;
    angle_t                angle;
  } sq_pay_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       err;
    angle_t     angle;
  } div_pay_t;

  logic [DEPTH-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---- squared length and magnitudes
  logic signed [N2_W-1:0] sqx, sqy, sqz;
  logic [N2_W-1:0]        n2_d;
  sq_pay_t                pay_d;

  assign sqx  = ax_i * ax_i;
  assign sqy  = ay_i * ay_i;
  assign sqz  = az_i * az_i;
  assign n2_d = N2_W'(sqx) + N2_W'(sqy) + N2_W'(sqz);

  always_comb begin
    pay_d.mag[0] = ax_i[AXIS_W-1] ? MAG_W'(-ax_i) : MAG_W'(ax_i);
    pay_d.mag[1] = ay_i[AXIS_W-1] ? MAG_W'(-ay_i) : MAG_W'(ay_i);
    pay_d.mag[2] = az_i[AXIS_W-1] ? MAG_W'(-az_i) : MAG_W'(az_i);
    pay_d.neg    = {az_i[AXIS_W-1], ay_i[AXIS_W-1], ax_i[AXIS_W-1]};
    pay_d.err    = (ax_i == '0) && (ay_i == '0) && (az_i == '0);
    pay_d.angle  = angle_i;
  end

  // ---- square root, one result bit per stage
  sq_pay_t          sp_q    [SQ_STEPS+1];
  logic [N2_W-1:0]  srad_q  [SQ_STEPS+1];
  logic [REM_W-1:0] srem_q  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sroot_q [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sp_q[0]    <= pay_d;
      srad_q[0]  <= n2_d;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] rsh, trial;
    logic             ge;

    assign rsh   = {srem_q[k], srad_q[k][N2_W-1 -: 2]};
    assign trial = (REM_W+2)'({sroot_q[k], 2'b01});
    assign ge    = rsh >= trial;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sp_q[k+1]    <= sp_q[k];
        srad_q[k+1]  <= {srad_q[k][N2_W-3:0], 2'b00};
        srem_q[k+1]  <= ge ? REM_W'(rsh - trial) : REM_W'(rsh);
        sroot_q[k+1] <= {sroot_q[k][ROOT_W-2:0], ge};
      end
    end
  end

  // ---- division setup: dividend = |a| * 2^46 + len / 2
  logic [NUM_W-1:0] num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {sp_q[SQ_STEPS].mag[i], {NUM_SHIFT{1'b0}}}
             + NUM_W'(sroot_q[SQ_STEPS] >> 1);
    end
  end

  div_pay_t          dp_q   [DIV_STEPS+1];
  logic [ROOT_W-1:0] dr_q   [DIV_STEPS+1];
  logic [DREM_W-1:0] drem_q [DIV_STEPS+1][3];
  logic [QUO_W-1:0]  dlo_q  [DIV_STEPS+1][3];
  logic [QUO_W-1:0]  dquo_q [DIV_STEPS+1][3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dp_q[0] <= '{neg: sp_q[SQ_STEPS].neg, err: sp_q[SQ_STEPS].err,
                   angle: sp_q[SQ_STEPS].angle};
      dr_q[0] <= sroot_q[SQ_STEPS];
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= DREM_W'(num[i][NUM_W-1:QUO_W]);
        dlo_q[0][i]  <= num[i][QUO_W-1:0];
        dquo_q[0][i] <= '0;
      end
    end
  end

  // ---- restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dp_q[j+1] <= dp_q[j];
        dr_q[j+1] <= dr_q[j];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [DREM_W:0] rsh, dvs;
      logic            ge;

      assign rsh = {drem_q[j][i], dlo_q[j][i][QUO_W-1]};
      assign dvs = {1'b0, dr_q[j]};
      assign ge  = rsh >= dvs;

      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          drem_q[j+1][i] <= ge ? DREM_W'(rsh - dvs) : DREM_W'(rsh);
          dlo_q[j+1][i]  <= {dlo_q[j][i][QUO_W-2:0], 1'b0};
          dquo_q[j+1][i] <= {dquo_q[j][i][QUO_W-2:0], ge};
        end
      end
    end
  end

  // ---- restore signs
  unit_t [2:0] u_d;
  norm_out_t   out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i] = dp_q[DIV_STEPS].neg[i] ? -unit_t'({1'b0, dquo_q[DIV_STEPS][i]})
                                      :  unit_t'({1'b0, dquo_q[DIV_STEPS][i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= '{err: dp_q[DIV_STEPS].err, u: u_d, angle: dp_q[DIV_STEPS].angle};
    end
  end

  assign out_valid_o = v_q[DEPTH-1];
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== src/aarm_cordic.sv =====
`default_nettype none
module aarm_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                in_valid_i,
  input  aarm_pkg::norm_out_t in_i,
  output logic                out_valid_o,
  output aarm_pkg::rot_in_t   out_o
);
  import aarm_pkg::*;

  localparam int DEPTH   = CORDIC_STEPS + 2;
  localparam int Z_SHIFT = TURN_W - ANGLE_W;

  localparam angle_t HALF_QUARTER = angle_t'(1) << (ANGLE_W - 3);
  localparam logic signed [TRIG_W-1:0] ONE_Q30 = TRIG_W'(1) <<< UNIT_FRAC;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  typedef struct packed {
    logic        err;
    unit_t [2:0] u;
    quad_e       quad;
  } cpay_t;

  logic [DEPTH-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---- split angle into quadrant and residual in [-1/8, 1/8) turn
  angle_t                   sum, resid;
  logic signed [TRIG_W-1:0] z0;

  assign sum   = in_i.angle + HALF_QUARTER;
  assign resid = in_i.angle - {sum[ANGLE_W-1 -: 2], {(ANGLE_W-2){1'b0}}};
  assign z0    = TRIG_W'($signed({resid, {Z_SHIFT{1'b0}}}));

  cpay_t                    cp_q [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cx_q [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cy_q [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cz_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cp_q[0] <= '{err: in_i.err, u: in_i.u, quad: quad_e'(sum[ANGLE_W-1 -: 2])};
      cx_q[0] <= CORDIC_GAIN_Q30;
      cy_q[0] <= '0;
      cz_q[0] <= z0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [TRIG_W-1:0] xs, ys, at;

    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    assign at = atan_step(i);

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        cp_q[i+1] <= cp_q[i];
        if (!cz_q[i][TRIG_W-1]) begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + at;
        end
      end
    end
  end

  // ---- rotate by whole quadrants
  logic signed [TRIG_W-1:0] c_d, s_d;
  rot_in_t                  out_q;

  always_comb begin
    unique case (cp_q[CORDIC_STEPS].quad)
      QUAD_0: begin
        c_d = cx_q[CORDIC_STEPS];
        s_d = cy_q[CORDIC_STEPS];
      end
      QUAD_1: begin
        c_d = -cy_q[CORDIC_STEPS];
        s_d = cx_q[CORDIC_STEPS];
      end
      QUAD_2: begin
        c_d = -cx_q[CORDIC_STEPS];
        s_d = -cy_q[CORDIC_STEPS];
      end
      default: begin
        c_d = cy_q[CORDIC_STEPS];
        s_d = -cx_q[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= '{err: cp_q[CORDIC_STEPS].err, u: cp_q[CORDIC_STEPS].u,
                 c: UNIT_W'(c_d), s: UNIT_W'(s_d), t: T_W'(ONE_Q30 - c_d)};
    end
  end

  assign out_valid_o = v_q[DEPTH-1];
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== src/aarm_matrix.sv =====
`default_nettype none
module aarm_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  aarm_pkg::rot_in_t  in_i,
  output logic               out_valid_o,
  output aarm_pkg::mat_out_t out_o
);
  import aarm_pkg::*;

  localparam int DEPTH    = 5;
  localparam int PP_W     = 2 * UNIT_W;
  localparam int TP_W     = T_W + UNIT_W;
  localparam int SUM_W    = TP_W + 1;
  localparam int RND_SH   = 2 * UNIT_FRAC - FRAC_BITS;

  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;

  localparam logic signed [PP_W-1:0]  HALF_Q30 = PP_W'(1) <<< (UNIT_FRAC - 1);
  localparam logic signed [SUM_W-1:0] HALF_OUT = SUM_W'(1) <<< (RND_SH - 1);
  localparam logic signed [SUM_W-1:0] EMAX = (SUM_W'(1) <<< (ELEMENT_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] EMIN = -EMAX - SUM_W'(1);

  function automatic elem_t to_elem(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    elem_t                   e;
    r = (v + HALF_OUT) >>> RND_SH;
    if (r > EMAX) begin
      e = elem_t'(EMAX);
    end else if (r < EMIN) begin
      e = elem_t'(EMIN);
    end else begin
      e = elem_t'(r);
    end
    return e;
  endfunction

  logic [DEPTH-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // ---- axis pair products
  logic signed [PP_W-1:0] pp_d [6];
  logic signed [PP_W-1:0] pp_q [6];
  rot_in_t                r1_q;

  always_comb begin
    pp_d[P_XX] = $signed(in_i.u[0]) * $signed(in_i.u[0]);
    pp_d[P_YY] = $signed(in_i.u[1]) * $signed(in_i.u[1]);
    pp_d[P_ZZ] = $signed(in_i.u[2]) * $signed(in_i.u[2]);
    pp_d[P_XY] = $signed(in_i.u[0]) * $signed(in_i.u[1]);
    pp_d[P_XZ] = $signed(in_i.u[0]) * $signed(in_i.u[2]);
    pp_d[P_YZ] = $signed(in_i.u[1]) * $signed(in_i.u[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pp_q <= pp_d;
      r1_q <= in_i;
    end
  end

  // ---- round pair products back to Q30
  logic signed [UNIT_W-1:0] pq_q [6];
  rot_in_t                  r2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int p = 0; p < 6; p++) begin
        pq_q[p] <= UNIT_W'((pp_q[p] + HALF_Q30) >>> UNIT_FRAC);
      end
      r2_q <= r1_q;
    end
  end

  // ---- t and s products
  logic signed [TP_W-1:0]   tp_q [6];
  logic signed [PP_W-1:0]   sp_q [3];
  logic signed [UNIT_W-1:0] c3_q;
  logic                     err3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int p = 0; p < 6; p++) begin
        tp_q[p] <= $signed(r2_q.t) * pq_q[p];
      end
      for (int i = 0; i < 3; i++) begin
        sp_q[i] <= $signed(r2_q.s) * $signed(r2_q.u[i]);
      end
      c3_q   <= r2_q.c;
      err3_q <= r2_q.err;
    end
  end

  // ---- element sums in Q60
  logic signed [SUM_W-1:0] tpe [6];
  logic signed [SUM_W-1:0] spe [3];
  logic signed [SUM_W-1:0] cq;
  logic signed [SUM_W-1:0] e_d [3][3];
  logic signed [SUM_W-1:0] e_q [3][3];
  logic                    err4_q;

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      tpe[p] = SUM_W'(tp_q[p]);
    end
    for (int i = 0; i < 3; i++) begin
      spe[i] = SUM_W'(sp_q[i]);
    end
    cq = SUM_W'(c3_q) <<< UNIT_FRAC;
    e_d[0][0] = tpe[P_XX] + cq;
    e_d[0][1] = tpe[P_XY] + spe[2];
    e_d[0][2] = tpe[P_XZ] - spe[1];
    e_d[1][0] = tpe[P_XY] - spe[2];
    e_d[1][1] = tpe[P_YY] + cq;
    e_d[1][2] = tpe[P_YZ] + spe[0];
    e_d[2][0] = tpe[P_XZ] + spe[1];
    e_d[2][1] = tpe[P_YZ] - spe[0];
    e_d[2][2] = tpe[P_ZZ] + cq;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_q    <= e_d;
      err4_q <= err3_q;
    end
  end

  // ---- round, saturate, substitute identity for a zero axis
  mat_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.err <= err4_q;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          if (err4_q) begin
            out_q.m[k][r] <= (k == r) ? ELEM_ONE : '0;
          end else begin
            out_q.m[k][r] <= to_elem(e_q[k][r]);
          end
        end
      end
    end
  end

  assign out_valid_o = v_q[DEPTH-1];
  assign out_o       = out_q;

endmodule
`default_nettype wire

// ===== src/axis_angle_rotation_matrix_unit.sv =====
`default_nettype none
// Axis-angle to 4x4 rotation matrix. Each accepted transfer (axis x/y/z, binary
// angle) produces four output transfers, columns 0 to 3 in order, elements in
// signed Q1.(ELEMENT_WIDTH-2); column 3 is always (0,0,0,1) and a zero axis gives
// the identity with axis_error set. The block is a fixed pipeline of 89 register
// stages (a 66-stage square-root and divide normalizer, a CORDIC of
// TRIG_ITERATIONS + 2 stages, a 5-stage product and rounding section) followed
// by a column register. Sustained throughput is bounded by the single output
// port, which carries one column per cycle while out_stall_i is low; inputs are
// taken in consecutive cycles while the pipeline has room, and a stall on the
// output holds the whole pipeline once a matrix waits at its tail.
module axis_angle_rotation_matrix_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  aarm_pkg::axis_t  axis_x_i,
  input  aarm_pkg::axis_t  axis_y_i,
  input  aarm_pkg::axis_t  axis_z_i,
  input  aarm_pkg::angle_t angle_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       column_index_o,
  output aarm_pkg::elem_t  elem_row0_o,
  output aarm_pkg::elem_t  elem_row1_o,
  output aarm_pkg::elem_t  elem_row2_o,
  output aarm_pkg::elem_t  elem_row3_o,
  output logic             axis_error_o,
  output logic             last_column_o
);
  import aarm_pkg::*;

  logic      adv;
  logic      n_valid, r_valid, m_valid;
  norm_out_t n_data;
  rot_in_t   r_data;
  mat_out_t  m_data;

  aarm_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .ax_i        (axis_x_i),
    .ay_i        (axis_y_i),
    .az_i        (axis_z_i),
    .angle_i     (angle_i),
    .out_valid_o (n_valid),
    .out_o       (n_data)
  );

  aarm_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (n_valid),
    .in_i        (n_data),
    .out_valid_o (r_valid),
    .out_o       (r_data)
  );

  aarm_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (r_valid),
    .in_i        (r_data),
    .out_valid_o (m_valid),
    .out_o       (m_data)
  );

  // ---- column register
  logic             busy_q;
  logic [COL_W-1:0] col_q;
  mat_t             mat_q;
  logic             err_q;
  logic             out_xfer, last_xfer, ser_free, take;

  assign out_xfer  = busy_q && !out_stall_i;
  assign last_xfer = out_xfer && (col_q == LAST_COL);
  assign ser_free  = !busy_q || last_xfer;
  assign take      = m_valid && ser_free;
  // advance when the pipeline tail is empty or moves into the column register
  assign adv       = !m_valid || ser_free;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
    end else begin
      priority if (take) begin
        busy_q <= 1'b1;
        col_q  <= '0;
      end else if (last_xfer) begin
        busy_q <= 1'b0;
      end else if (out_xfer) begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mat_q <= m_data.m;
      err_q <= m_data.err;
    end
  end

  always_comb begin
    elem_row0_o = '0;
    elem_row1_o = '0;
    elem_row2_o = '0;
    elem_row3_o = '0;
    if (col_q == LAST_COL) begin
      elem_row3_o = ELEM_ONE;
    end else begin
      elem_row0_o = mat_q[col_q][0];
      elem_row1_o = mat_q[col_q][1];
      elem_row2_o = mat_q[col_q][2];
    end
  end

  assign out_valid_o    = busy_q;
  assign column_index_o = col_q;
  assign axis_error_o   = err_q;
  assign last_column_o  = (col_q == LAST_COL);

  // ---- assertions
  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !in_stall_o)
    else $error("input stalled while column register is empty");

  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_column_o |=>
      out_valid_o && (column_index_o == $past(column_index_o) + 2'd1))
    else $error("column sequence broken after transfer");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_column_o |->
      (elem_row3_o == ELEM_ONE) && (elem_row0_o == '0) &&
      (elem_row1_o == '0) && (elem_row2_o == '0))
    else $error("homogeneous column is wrong");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && axis_error_o && !last_column_o |->
      ((elem_row0_o == ELEM_ONE) == (column_index_o == 2'd0)) &&
      (elem_row3_o == '0))
    else $error("zero axis did not give identity");

endmodule
`default_nettype wire
